/* hw/rtl/bvap_pkg.sv */
package bvap_pkg;

    localparam int PIN_W       = 12;
    localparam int READING_W   = 13;
    localparam int PCT_W       = 7;
    localparam int CFG_W       = 5;
    localparam int SIZE_RESET  = 8;
    localparam int SIZE_LIMIT  = 31;

    localparam int AVERAGE_MAX  = 8190;
    localparam int POINT_COUNT  = 21;
    localparam int SEG_W        = 5;
    localparam int PERCENT_STEP = 5;
    localparam int PERCENT_FULL = 100;
    localparam int GAUGE_DEN_W  = 9;

    localparam logic [READING_W-1:0] GAUGE_POINTS [POINT_COUNT] = '{
        13'd3270,
        13'd3610, 13'd3690, 13'd3710, 13'd3730, 13'd3750,
        13'd3770, 13'd3790, 13'd3800, 13'd3820, 13'd3840,
        13'd3850, 13'd3870, 13'd3910, 13'd3950, 13'd3980,
        13'd4020, 13'd4080, 13'd4110, 13'd4150, 13'd4200
    };

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic int tot_width(input int depth);
        return $clog2(depth * AVERAGE_MAX + 1);
    endfunction

    function automatic int cnt_width(input int depth);
        int cap;
        cap = (depth < SIZE_LIMIT) ? depth : SIZE_LIMIT;
        return $clog2(cap + 1);
    endfunction

    function automatic int cnt_cap(input int depth);
        return (depth < SIZE_LIMIT) ? depth : SIZE_LIMIT;
    endfunction

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* hw/rtl/bvap_in_if.sv */
interface bvap_in_if import bvap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] pin_millivolts;

    modport source (output valid, output pin_millivolts, input ready);
    modport sink (input valid, input pin_millivolts, output ready);
endinterface

/* hw/rtl/bvap_out_if.sv */
interface bvap_out_if import bvap_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [READING_W-1:0] average_millivolts;
    logic [PCT_W-1:0]     charge_percent;

    modport source (output valid, output average_millivolts, output charge_percent,
                    input ready);
    modport sink (input valid, input average_millivolts, input charge_percent,
                  output ready);
endinterface

/* hw/rtl/bvap_ram.sv */
module bvap_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bvap_div.sv */
module bvap_div import bvap_pkg::*; #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (shifted >= {1'b0, den_reg});
        diff      = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/bvap_fifo.sv */
module bvap_fifo #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/bvap_front.sv */
module bvap_front import bvap_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    bvap_in_if.sink                               reading,
    input  logic [CFG_W-1:0]                      window_size,
    output logic                                  q_push,
    output logic [tot_width(WINDOW_DEPTH)+cnt_width(WINDOW_DEPTH)-1:0] q_data,
    input  logic                                  q_ready
);

    localparam int TOT_W = tot_width(WINDOW_DEPTH);
    localparam int CNT_W = cnt_width(WINDOW_DEPTH);
    localparam int IDX_W = idx_width(WINDOW_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [READING_W-1:0]    value_reg, value_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]        size_eff;
    logic [READING_W-1:0]    old_value;
    logic [READING_W-1:0]    ram_rdata;
    logic                    ram_we;
    logic                    div_start;
    div_stat_t               div_stat;
    logic [IDX_W:0]          div_quo;
    logic [CNT_W-1:0]        div_rem;

    always_comb
    begin
        if (window_size == '0)
        begin
            size_eff = CNT_W'(1);
        end
        else if (int'(window_size) > WINDOW_DEPTH)
        begin
            size_eff = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            size_eff = CNT_W'(window_size);
        end
    end

    assign reading.ready = (state_reg == ST_IDLE);
    assign old_value     = valid_reg[pos_reg] ? ram_rdata : '0;
    assign q_data        = {total_reg, fill_reg};

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        valid_next = valid_reg;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (reading.valid)
                begin
                    value_next = {reading.pin_millivolts, 1'b0};
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                total_next          = total_reg + TOT_W'(value_reg) - TOT_W'(old_value);
                ram_we              = 1'b1;
                valid_next[pos_reg] = 1'b1;
                if (fill_reg < size_eff)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                div_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (div_stat.done)
                begin
                    pos_next   = IDX_W'(div_rem);
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                q_push = 1'b1;
                if (q_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    bvap_ram #(
        .WIDTH (READING_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (value_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    bvap_div #(
        .NUM_W (IDX_W + 1),
        .DEN_W (CNT_W)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ({1'b0, pos_reg} + (IDX_W + 1)'(1)),
        .divisor   (size_eff),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= cnt_cap(WINDOW_DEPTH))
        else $error("fill count beyond window capacity");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < WINDOW_DEPTH)
        else $error("write position out of range");

    a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && div_stat.done) |-> (div_quo <= (IDX_W + 1)'(WINDOW_DEPTH)))
        else $error("wrap quotient out of range");

endmodule

/* hw/rtl/bvap_back.sv */
module bvap_back import bvap_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  logic [tot_width(WINDOW_DEPTH)+cnt_width(WINDOW_DEPTH)-1:0] q_data,
    output logic                                  q_pop,
    bvap_out_if.source                            gauge
);

    localparam int TOT_W = tot_width(WINDOW_DEPTH);
    localparam int CNT_W = cnt_width(WINDOW_DEPTH);
    localparam int DV_W  = (CNT_W > GAUGE_DEN_W) ? CNT_W : GAUGE_DEN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AVG  = 3'd1;
    localparam logic [2:0] ST_SEG  = 3'd2;
    localparam logic [2:0] ST_LOOK = 3'd3;
    localparam logic [2:0] ST_PCT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [READING_W-1:0]   avg_reg, avg_next;
    logic [SEG_W-1:0]       seg_reg, seg_next;
    logic [PCT_W-1:0]       pct_reg, pct_next;
    logic                   out_valid_reg, out_valid_next;
    logic [READING_W-1:0]   out_avg_reg, out_avg_next;
    logic [PCT_W-1:0]       out_pct_reg, out_pct_next;
    logic [POINT_COUNT-1:0] above;
    logic [READING_W-1:0]   seg_lo, seg_hi, seg_off;
    logic [READING_W+2:0]   num5;
    logic                   div_start;
    logic [TOT_W-1:0]       div_num;
    logic [DV_W-1:0]        div_den;
    div_stat_t              div_stat;
    logic [TOT_W-1:0]       div_quo;
    logic [DV_W-1:0]        div_rem;

    always_comb
    begin
        for (int i = 0; i < POINT_COUNT; i++)
        begin
            above[i] = (avg_reg >= GAUGE_POINTS[i]);
        end
    end

    assign seg_lo  = GAUGE_POINTS[seg_reg - SEG_W'(1)];
    assign seg_hi  = GAUGE_POINTS[seg_reg];
    assign seg_off = avg_reg - seg_lo;
    assign num5    = {1'b0, seg_off, 2'b00} + {3'b000, seg_off};

    assign gauge.valid              = out_valid_reg;
    assign gauge.average_millivolts = out_avg_reg;
    assign gauge.charge_percent     = out_pct_reg;

    always_comb
    begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        seg_next       = seg_reg;
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg && !gauge.ready;
        out_avg_next   = out_avg_reg;
        out_pct_next   = out_pct_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_num        = q_data[TOT_W+CNT_W-1:CNT_W];
        div_den        = DV_W'(q_data[CNT_W-1:0]);
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (div_stat.done)
                begin
                    if (div_quo > TOT_W'(AVERAGE_MAX))
                    begin
                        avg_next = READING_W'(AVERAGE_MAX);
                    end
                    else
                    begin
                        avg_next = div_quo[READING_W-1:0];
                    end
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                seg_next   = SEG_W'($countones(above));
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (seg_reg == '0)
                begin
                    pct_next   = '0;
                    state_next = ST_OUT;
                end
                else if (seg_reg == SEG_W'(POINT_COUNT))
                begin
                    pct_next   = PCT_W'(PERCENT_FULL);
                    state_next = ST_OUT;
                end
                else
                begin
                    pct_next   = PCT_W'(PERCENT_STEP * (int'(seg_reg) - 1));
                    div_num    = TOT_W'(num5);
                    div_den    = DV_W'(seg_hi - seg_lo);
                    div_start  = 1'b1;
                    state_next = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (div_stat.done)
                begin
                    pct_next   = pct_reg + PCT_W'(div_quo);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || gauge.ready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_reg;
                    out_pct_next   = pct_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        seg_reg     <= seg_next;
        pct_reg     <= pct_next;
        out_avg_reg <= out_avg_next;
        out_pct_reg <= out_pct_next;
    end

    bvap_div #(
        .NUM_W (TOT_W),
        .DEN_W (DV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pct_reg <= PCT_W'(PERCENT_FULL)))
        else $error("charge percent above full");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_avg_reg <= READING_W'(AVERAGE_MAX)))
        else $error("average above range");

    a_gauge_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PCT && div_stat.done) |->
            (div_quo < TOT_W'(PERCENT_STEP) && div_rem < DV_W'(seg_hi - seg_lo)))
        else $error("segment interpolation out of step");

endmodule

/* hw/rtl/battery_voltage_average_to_percent.sv */
// Moving average of doubled pin voltages over a window of 1 to WINDOW_DEPTH
// readings, with a charge estimate from 21 breakpoints interpolated in 5%
// steps. Each reading beat yields one result beat. The front end takes a beat,
// reads and rewrites the window memory and wraps the write position with a
// serial remainder unit. Results wait in a two-entry queue for the back end,
// whose single bit-serial divider runs the average division and then, for an
// average at or above the first breakpoint and below the last, the segment
// interpolation, one quotient bit per cycle. The back end takes one queued
// entry at a time and sets the sustained rate; the running total is 17 bits
// wide at depth 16. The window size register is taken as 1 when zero and as
// WINDOW_DEPTH above it; write it only while no beat is in flight.
module battery_voltage_average_to_percent import bvap_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    bvap_in_if.sink          reading,
    bvap_out_if.source       gauge,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int Q_W = tot_width(WINDOW_DEPTH) + cnt_width(WINDOW_DEPTH);

    logic [CFG_W-1:0] size_reg;
    logic             q_push, q_ready, q_pop, q_valid;
    logic [Q_W-1:0]   q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= CFG_W'(SIZE_RESET);
        end
        else if (cfg_write)
        begin
            size_reg <= cfg_data;
        end
    end

    bvap_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .reading     (reading),
        .window_size (size_reg),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_ready     (q_ready)
    );

    bvap_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    bvap_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .gauge   (gauge)
    );

endmodule

/* dv/window_gauge_checker.sv */
module window_gauge_checker import bvap_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    bvap_in_if               reading,
    bvap_out_if              gauge,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatches,
    output int               compared,
    output int               outstanding
);

    typedef struct packed {
        logic [READING_W-1:0] average_millivolts;
        logic [PCT_W-1:0]     charge_percent;
    } gauge_beat_t;

    gauge_beat_t      due_gauge [$];
    int unsigned      window_mem [DEPTH];
    int unsigned      window_sum;
    int unsigned      next_slot;
    int unsigned      readings_held;
    logic [CFG_W-1:0] window_size;
    int               fail_count;
    int               beat_count;

    function automatic logic [PCT_W-1:0] charge_of(input int unsigned mv);
        int unsigned lo;
        int unsigned hi;
        if (mv < GAUGE_POINTS[0])
            return '0;
        lo = GAUGE_POINTS[0];
        for (int k = 1; k < POINT_COUNT; k++)
        begin
            hi = GAUGE_POINTS[k];
            if (mv < hi)
                return PCT_W'(PERCENT_STEP * (k - 1) + (PERCENT_STEP * (mv - lo)) / (hi - lo));
            lo = hi;
        end
        return PCT_W'(PERCENT_FULL);
    endfunction

    function automatic gauge_beat_t advance_window(input logic [PIN_W-1:0] pin);
        int unsigned span;
        int unsigned doubled;
        int unsigned slot;
        int unsigned average;
        gauge_beat_t beat;
        span = (window_size == 0) ? 1 : ((window_size > DEPTH) ? DEPTH : window_size);
        doubled = 2 * pin;
        slot = (next_slot >= DEPTH) ? 0 : next_slot;
        window_sum = window_sum + doubled - window_mem[slot];
        window_mem[slot] = doubled;
        next_slot = (slot + 1) % span;
        if (readings_held < span)
            readings_held++;
        average = window_sum / readings_held;
        if (average > AVERAGE_MAX)
            average = AVERAGE_MAX;
        beat.average_millivolts = READING_W'(average);
        beat.charge_percent = charge_of(average);
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gauge_beat_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                window_mem[k] = 0;
            window_sum = 0;
            next_slot = 0;
            readings_held = 0;
            window_size = CFG_W'(SIZE_RESET);
            due_gauge.delete();
            fail_count = 0;
            beat_count = 0;
        end
        else
        begin
            if (gauge.valid && gauge.ready)
            begin
                if (due_gauge.size() == 0)
                begin
                    $display("%0t: gauge beat with no reading outstanding (average %0d, percent %0d)",
                             $time, gauge.average_millivolts, gauge.charge_percent);
                    fail_count++;
                end
                else
                begin
                    want = due_gauge.pop_front();
                    beat_count++;
                    if (gauge.average_millivolts !== want.average_millivolts)
                    begin
                        $display("%0t: average_millivolts expected %0d, got %0d",
                                 $time, want.average_millivolts, gauge.average_millivolts);
                        fail_count++;
                    end
                    if (gauge.charge_percent !== want.charge_percent)
                    begin
                        $display("%0t: charge_percent expected %0d, got %0d",
                                 $time, want.charge_percent, gauge.charge_percent);
                        fail_count++;
                    end
                end
            end
            if (reading.valid && reading.ready)
                due_gauge.push_back(advance_window(reading.pin_millivolts));
            if (cfg_write)
                window_size = cfg_data;
        end
        mismatches <= fail_count;
        compared <= beat_count;
        outstanding <= due_gauge.size();
    end

endmodule

/* dv/tb.sv */
module tb;
    import bvap_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PIN_MAX      = (1 << PIN_W) - 1;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int STALL_CYCLES = 400;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 157;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [CFG_W-1:0] PHASE_SIZES [10] = '{
        5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd2, 5'd17, 5'd12, 5'd3, 5'd16
    };
    localparam logic [PIN_W-1:0] EDGE_READINGS [7] = '{
        12'd2048, 12'd1365, 12'd2730, 12'd1634, 12'd1635, 12'd2099, 12'd2100
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write;
    logic [CFG_W-1:0] cfg_data;
    int               tx_idle = 22;
    int               rx_idle = 74;
    logic             stall_req = 1'b0;
    int               readings_sent = 0;
    int               quiet = 0;
    int               mismatches;
    int               compared;
    int               pending;

    bvap_in_if  reading_if ();
    bvap_out_if gauge_if ();

    battery_voltage_average_to_percent #(.WINDOW_DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .reading   (reading_if),
        .gauge     (gauge_if),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    window_gauge_checker #(.DEPTH(DEPTH)) i_gauge_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .reading     (reading_if),
        .gauge       (gauge_if),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .compared    (compared),
        .outstanding (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (reading_if.valid && reading_if.ready) || (gauge_if.valid && gauge_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : receiver
        int  hold_left;
        bit  stall_done;
        hold_left = 0;
        stall_done = 1'b0;
        gauge_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_done)
            begin
                hold_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                gauge_if.ready <= 1'b0;
            end
            else
                gauge_if.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_reading(input logic [PIN_W-1:0] value);
        while ($urandom_range(99) < tx_idle)
        begin
            reading_if.valid <= 1'b0;
            @(posedge clk);
        end
        reading_if.valid <= 1'b1;
        reading_if.pin_millivolts <= value;
        @(posedge clk);
        while (!reading_if.ready)
            @(posedge clk);
        readings_sent++;
    endtask

    task automatic send_run(input logic [PIN_W-1:0] value, input int count);
        repeat (count) send_reading(value);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] size);
        reading_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= size;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [PIN_W-1:0] pick_level();
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 50)
            v = int'(GAUGE_POINTS[$urandom_range(POINT_COUNT - 1)]) / 2
                + int'($urandom_range(2)) - 1;
        else if (roll < 80)
            v = $urandom_range(2110, 1600);
        else
            v = $urandom_range(PIN_MAX);
        return PIN_W'(v);
    endfunction

    initial
    begin : stimulus
        int start;
        int kind;
        int base;
        int v;
        reading_if.valid <= 1'b0;
        reading_if.pin_millivolts <= '0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial fill at the reset size, then shrink so the total outgrows the count
        send_run(PIN_W'(PIN_MAX), 5);
        set_window(5'd2);
        send_run(PIN_W'(PIN_MAX), 2);
        set_window(5'd0);
        send_reading(12'd0);
        send_reading(PIN_W'(PIN_MAX));
        send_reading(12'd1);
        set_window(5'd31);
        foreach (EDGE_READINGS[i])
            send_reading(EDGE_READINGS[i]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                tx_idle = 22;
                rx_idle = 74;
            end
            else if (ph < 8)
            begin
                tx_idle = 74;
                rx_idle = 22;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            set_window((ph < 10) ? PHASE_SIZES[ph] : CFG_W'($urandom_range(31)));
            if (ph == 8)
                stall_req = 1'b1;
            start = readings_sent;
            while (readings_sent - start < PHASE_ITEMS)
            begin
                kind = $urandom_range(9);
                if (kind < 6)
                    send_run(pick_level(), $urandom_range(20, 4));
                else if (kind < 8)
                begin
                    base = int'(pick_level());
                    repeat ($urandom_range(12, 4))
                    begin
                        v = base + int'($urandom_range(20)) - 10;
                        if (v < 0)
                            v = 0;
                        else if (v > PIN_MAX)
                            v = PIN_MAX;
                        send_reading(PIN_W'(v));
                    end
                end
                else if (kind == 8)
                    send_reading(PIN_W'($urandom_range(PIN_MAX)));
                else
                    send_run(PIN_W'(($urandom_range(1) != 0) ? PIN_MAX : 0), $urandom_range(3, 1));
            end
        end

        reading_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d readings over %0d window settings, checked %0d gauge beats.",
                 readings_sent, PHASES + 3, compared);
        $display("Covered partial fill, shrink past the fill count, sizes 0 and above depth, %s",
                 "idle mixes and a long output stall.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
